### design/lrud_pkg.sv
// Shared types and codes for the LRU write-back block cache directory.
`timescale 1ns / 1ps
`default_nettype none
package lrud_pkg;

  localparam int STAMP_W = 32;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_INVAL = 2'd3
  } action_t;

  // candidate class carried down the chain: min stamp < empty entry < hit
  typedef enum logic [1:0] {
    CLS_MIN = 2'd0,
    CLS_INV = 2'd1,
    CLS_HIT = 2'd2
  } cls_t;

  // scan token control travelling from cell to cell
  typedef struct packed {
    logic    active;
    action_t op;
    cls_t    cls;
    logic    found;
    logic    dirty;
  } ctl_t;

  // entry update command broadcast to all cells
  typedef struct packed {
    logic clr;
    logic upd_hit;
    logic upd_miss;
    logic write;
  } cmd_t;

endpackage
`default_nettype wire

### design/lru_writeback_block_cache_directory.sv
// Top level: fully associative LRU write-back block cache directory.
// A read or write result is registered once the scan token has passed every cell of the chain.
// A read, write or flush is not accepted until its token leaves the chain; the token walks one
// entry per cycle unless the output stalls. Invalidate clears all entries and keeps in_ready high.
// Flush gives one result per dirty entry as the token passes it; output stalls freeze the chain.
// Reset (synchronous, rst_n low) empties every entry and zeroes the access counter.
`timescale 1ns / 1ps
`default_nettype none
module lru_writeback_block_cache_directory #(
  parameter int NUM_ENTRIES = 32,
  parameter int BLOCK_BITS  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_action,
  input  wire logic [BLOCK_BITS-1:0]          in_block_number,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_hit,
  output logic [$clog2(NUM_ENTRIES)-1:0]      out_entry_index,
  output logic                                out_writeback_needed,
  output logic [BLOCK_BITS-1:0]               out_writeback_block,
  output logic                                out_fill_needed,
  output logic                                out_last
);
  import lrud_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);

  ctl_t                  ctl_w   [0:NUM_ENTRIES];
  logic [IDX_W-1:0]      idx_w   [0:NUM_ENTRIES];
  logic [STAMP_W-1:0]    stamp_w [0:NUM_ENTRIES];
  logic [BLOCK_BITS-1:0] tag_w   [0:NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] emit;
  logic [NUM_ENTRIES-1:0] sel;

  logic                  busy_r;
  ctl_t                  inj_r, inj_nxt;
  logic [BLOCK_BITS-1:0] blk_r;
  logic [STAMP_W-1:0]    cnt_r;
  logic [STAMP_W-1:0]    stamp_nxt;
  logic                  adv;
  logic                  accept;
  action_t               in_act;
  ctl_t                  fin;
  logic                  fin_rw;
  cmd_t                  cmd;
  logic                  fl_emit;
  logic [IDX_W-1:0]      fl_idx;
  logic [BLOCK_BITS-1:0] fl_tag;

  logic                  ov_r, ov_nxt;
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      oidx_r, oidx_nxt;
  logic                  wb_r, wb_nxt;
  logic [BLOCK_BITS-1:0] wbblk_r, wbblk_nxt;
  logic                  fill_r, fill_nxt;
  logic                  last_r, last_nxt;

  assign in_act    = action_t'(in_action);
  assign in_ready  = !busy_r;
  assign accept    = in_valid && in_ready;
  assign adv       = !ov_r || out_ready;
  assign fin       = ctl_w[NUM_ENTRIES];
  assign fin_rw    = fin.active && (fin.op == ACT_READ || fin.op == ACT_WRITE);
  assign stamp_nxt = cnt_r + STAMP_W'(1);

  assign ctl_w[0]   = inj_r;
  assign idx_w[0]   = '0;
  assign stamp_w[0] = '0;
  assign tag_w[0]   = '0;

  assign cmd.clr      = accept && in_act == ACT_INVAL;
  assign cmd.upd_hit  = adv && fin_rw && fin.cls == CLS_HIT;
  assign cmd.upd_miss = adv && fin_rw && fin.cls != CLS_HIT;
  assign cmd.write    = fin.op == ACT_WRITE;

  genvar k;
  generate
    for (k = 0; k < NUM_ENTRIES; k++) begin : g_cell
      assign sel[k] = (idx_w[NUM_ENTRIES] == IDX_W'(k));
      lrud_cell #(
        .BLOCK_BITS(BLOCK_BITS),
        .IDX_W     (IDX_W),
        .INDEX     (k)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .ctl_i      (ctl_w[k]),
        .idx_i      (idx_w[k]),
        .stamp_i    (stamp_w[k]),
        .tag_i      (tag_w[k]),
        .blk_i      (blk_r),
        .cmd_i      (cmd),
        .sel_i      (sel[k]),
        .upd_stamp_i(stamp_nxt),
        .ctl_o      (ctl_w[k+1]),
        .idx_o      (idx_w[k+1]),
        .stamp_o    (stamp_w[k+1]),
        .tag_o      (tag_w[k+1]),
        .emit_o     (emit[k])
      );
    end
  endgenerate

  // at most one cell holds the token, so its pending flush entry is an AND-OR pick
  always_comb begin
    fl_idx = '0;
    fl_tag = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      fl_idx = fl_idx | (idx_w[i] & {IDX_W{emit[i]}});
      fl_tag = fl_tag | (tag_w[i] & {BLOCK_BITS{emit[i]}});
    end
  end
  assign fl_emit = |emit;

  always_comb begin
    inj_nxt = inj_r;
    if (adv) begin
      inj_nxt.active = 1'b0;
    end
    if (accept && in_act != ACT_INVAL) begin
      inj_nxt.active = 1'b1;
      inj_nxt.op     = in_act;
      inj_nxt.cls    = CLS_MIN;
      inj_nxt.found  = 1'b0;
      inj_nxt.dirty  = 1'b0;
    end
  end

  always_comb begin
    ov_nxt    = ov_r && !out_ready;
    hit_nxt   = hit_r;
    oidx_nxt  = oidx_r;
    wb_nxt    = wb_r;
    wbblk_nxt = wbblk_r;
    fill_nxt  = fill_r;
    last_nxt  = last_r;
    if (adv) begin
      if (fin_rw) begin
        ov_nxt    = 1'b1;
        hit_nxt   = fin.cls == CLS_HIT;
        oidx_nxt  = idx_w[NUM_ENTRIES];
        wb_nxt    = fin.cls == CLS_MIN && fin.dirty;
        wbblk_nxt = (fin.cls == CLS_MIN && fin.dirty) ? tag_w[NUM_ENTRIES] : '0;
        fill_nxt  = fin.cls != CLS_HIT && fin.op == ACT_READ;
        last_nxt  = 1'b1;
      end else if (fin.active && fin.found) begin
        ov_nxt    = 1'b1;
        hit_nxt   = 1'b0;
        oidx_nxt  = idx_w[NUM_ENTRIES];
        wb_nxt    = 1'b1;
        wbblk_nxt = tag_w[NUM_ENTRIES];
        fill_nxt  = 1'b0;
        last_nxt  = 1'b1;
      end else if (fl_emit) begin
        ov_nxt    = 1'b1;
        hit_nxt   = 1'b0;
        oidx_nxt  = fl_idx;
        wb_nxt    = 1'b1;
        wbblk_nxt = fl_tag;
        fill_nxt  = 1'b0;
        last_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      inj_r  <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      inj_r <= inj_nxt;
      ov_r  <= ov_nxt;
      if (accept && in_act != ACT_INVAL) begin
        busy_r <= 1'b1;
      end else if (adv && fin.active) begin
        busy_r <= 1'b0;
      end
      if (adv && fin_rw) begin
        cnt_r <= stamp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r <= in_block_number;
    end
    hit_r   <= hit_nxt;
    oidx_r  <= oidx_nxt;
    wb_r    <= wb_nxt;
    wbblk_r <= wbblk_nxt;
    fill_r  <= fill_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid            = ov_r;
  assign out_hit              = hit_r;
  assign out_entry_index      = oidx_r;
  assign out_writeback_needed = wb_r;
  assign out_writeback_block  = wbblk_r;
  assign out_fill_needed      = fill_r;
  assign out_last             = last_r;

endmodule
`default_nettype wire

### design/lrud_cell.sv
// One directory entry with its stage of the lookup, victim and flush scan chain.
`timescale 1ns / 1ps
`default_nettype none
module lrud_cell #(
  parameter int BLOCK_BITS = 32,
  parameter int IDX_W      = 5,
  parameter int INDEX      = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire lrud_pkg::ctl_t              ctl_i,
  input  wire logic [IDX_W-1:0]            idx_i,
  input  wire logic [lrud_pkg::STAMP_W-1:0] stamp_i,
  input  wire logic [BLOCK_BITS-1:0]       tag_i,
  input  wire logic [BLOCK_BITS-1:0]       blk_i,
  input  wire lrud_pkg::cmd_t              cmd_i,
  input  wire logic                        sel_i,
  input  wire logic [lrud_pkg::STAMP_W-1:0] upd_stamp_i,
  output lrud_pkg::ctl_t                   ctl_o,
  output logic [IDX_W-1:0]                 idx_o,
  output logic [lrud_pkg::STAMP_W-1:0]     stamp_o,
  output logic [BLOCK_BITS-1:0]            tag_o,
  output logic                             emit_o
);
  import lrud_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                  valid_r;
  logic                  dirty_r;
  logic [BLOCK_BITS-1:0] tag_r;
  logic [STAMP_W-1:0]    stamp_r;

  ctl_t                  ctl_r, ctl_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [STAMP_W-1:0]    cst_r, cst_nxt;
  logic [BLOCK_BITS-1:0] ctag_r, ctag_nxt;
  logic                  flush_clr;
  logic                  is_hit;

  assign is_hit = valid_r && (tag_r == blk_i);

  always_comb begin
    ctl_nxt   = ctl_i;
    idx_nxt   = idx_i;
    cst_nxt   = stamp_i;
    ctag_nxt  = tag_i;
    emit_o    = 1'b0;
    flush_clr = 1'b0;
    if (ctl_i.active) begin
      case (ctl_i.op)
        ACT_FLUSH: begin
          if (dirty_r) begin
            emit_o        = ctl_i.found;
            flush_clr     = 1'b1;
            ctl_nxt.found = 1'b1;
            idx_nxt       = MY_IDX;
            ctag_nxt      = tag_r;
          end
        end
        ACT_READ, ACT_WRITE: begin
          if (is_hit && ctl_i.cls != CLS_HIT) begin
            ctl_nxt.cls = CLS_HIT;
            idx_nxt     = MY_IDX;
          end else if (!valid_r && ctl_i.cls == CLS_MIN) begin
            ctl_nxt.cls = CLS_INV;
            idx_nxt     = MY_IDX;
          end else if (valid_r && ctl_i.cls == CLS_MIN &&
                       (!ctl_i.found || stamp_r < stamp_i)) begin
            ctl_nxt.found = 1'b1;
            ctl_nxt.dirty = dirty_r;
            idx_nxt       = MY_IDX;
            cst_nxt       = stamp_r;
            ctag_nxt      = tag_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      ctl_r   <= '0;
    end else begin
      if (adv) begin
        ctl_r  <= ctl_nxt;
        idx_r  <= idx_nxt;
        cst_r  <= cst_nxt;
        ctag_r <= ctag_nxt;
      end
      if (cmd_i.clr) begin
        valid_r <= 1'b0;
        dirty_r <= 1'b0;
      end else if (sel_i && cmd_i.upd_hit) begin
        stamp_r <= upd_stamp_i;
        dirty_r <= dirty_r | cmd_i.write;
      end else if (sel_i && cmd_i.upd_miss) begin
        tag_r   <= blk_i;
        valid_r <= 1'b1;
        dirty_r <= cmd_i.write;
        stamp_r <= upd_stamp_i;
      end else if (adv && flush_clr) begin
        dirty_r <= 1'b0;
      end
    end
  end

  assign ctl_o   = ctl_r;
  assign idx_o   = idx_r;
  assign stamp_o = cst_r;
  assign tag_o   = ctag_r;

endmodule
`default_nettype wire

### design/lrud_checker.sv
// Port-level checks for the cache directory, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lrud_checker #(
  parameter int IDX_W      = 5,
  parameter int BLOCK_BITS = 32
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [1:0]            in_action,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_hit,
  input wire logic [IDX_W-1:0]      out_entry_index,
  input wire logic                  out_writeback_needed,
  input wire logic [BLOCK_BITS-1:0] out_writeback_block,
  input wire logic                  out_fill_needed,
  input wire logic                  out_last
);
  import lrud_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_index) &&
      $stable(out_writeback_block) && $stable(out_last))
    else $error("result transaction changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action != ACT_INVAL |=> !in_ready)
    else $error("new transaction taken while lookup in flight");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_writeback_needed && !out_fill_needed && out_last)
    else $error("hit result carries writeback or fill");

  a_fill_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_needed |-> !out_hit && out_last)
    else $error("fill reported on non-final or hit result");

  a_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_writeback_needed |-> out_writeback_block == '0)
    else $error("writeback block nonzero without writeback");

endmodule

bind lru_writeback_block_cache_directory lrud_checker #(
  .IDX_W     ($clog2(NUM_ENTRIES)),
  .BLOCK_BITS(BLOCK_BITS)
) u_lrud_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_action           (in_action),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_hit             (out_hit),
  .out_entry_index     (out_entry_index),
  .out_writeback_needed(out_writeback_needed),
  .out_writeback_block (out_writeback_block),
  .out_fill_needed     (out_fill_needed),
  .out_last            (out_last)
);
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the LRU write-back block cache directory.
`timescale 1ns / 1ps
module testbench;
  import lrud_pkg::*;

  localparam int NUM_ENTRIES = 32;
  localparam int BLOCK_BITS  = 32;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int POOL_SIZE   = 48;

  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      entry;
    logic                  wb;
    logic [BLOCK_BITS-1:0] wb_block;
    logic                  fill;
    logic                  last;
  } dir_outcome_t;

  class directory_scoreboard;
    logic [BLOCK_BITS-1:0] tag [NUM_ENTRIES];
    bit                    valid [NUM_ENTRIES];
    bit                    dirty [NUM_ENTRIES];
    logic [31:0]           stamp [NUM_ENTRIES];
    logic [31:0]           access_count;
    dir_outcome_t          outcomes [$];
    int                    errors;
    int                    mismatches;

    function new();
      wipe_entries();
      access_count = '0;
      errors = 0;
      mismatches = 0;
    endfunction

    function void wipe_entries();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        tag[i] = '0;
        valid[i] = 0;
        dirty[i] = 0;
        stamp[i] = '0;
      end
    endfunction

    function int choose_victim();
      int best;
      best = 0;
      for (int i = 0; i < NUM_ENTRIES; i++)
        if (!valid[i]) return i;
      for (int i = 1; i < NUM_ENTRIES; i++)
        if (stamp[i] < stamp[best]) best = i;
      return best;
    endfunction

    function void note_request(action_t act, logic [BLOCK_BITS-1:0] blk);
      dir_outcome_t o;
      int v;
      int n;
      int k;
      bit found;
      o = '0;
      found = 1'b0;
      case (act)
        ACT_READ, ACT_WRITE: begin
          access_count = access_count + 32'd1;
          for (int i = 0; i < NUM_ENTRIES && !found; i++) begin
            if (valid[i] && tag[i] == blk) begin
              found = 1'b1;
              stamp[i] = access_count;
              if (act == ACT_WRITE) dirty[i] = 1'b1;
              o.hit = 1'b1;
              o.entry = IDX_W'(i);
            end
          end
          if (!found) begin
            v = choose_victim();
            if (valid[v] && dirty[v]) begin
              o.wb = 1'b1;
              o.wb_block = tag[v];
            end
            tag[v] = blk;
            valid[v] = 1'b1;
            dirty[v] = (act == ACT_WRITE);
            stamp[v] = access_count;
            o.entry = IDX_W'(v);
            o.fill = (act == ACT_READ);
          end
          o.last = 1'b1;
          outcomes.push_back(o);
        end
        ACT_FLUSH: begin
          n = 0;
          for (int i = 0; i < NUM_ENTRIES; i++)
            if (dirty[i]) n++;
          k = 0;
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (dirty[i]) begin
              o = '0;
              o.entry = IDX_W'(i);
              o.wb = 1'b1;
              o.wb_block = tag[i];
              o.last = (k == n - 1);
              outcomes.push_back(o);
              dirty[i] = 1'b0;
              k++;
            end
          end
        end
        default: wipe_entries();
      endcase
    endfunction

    function void check_outcome(dir_outcome_t got);
      dir_outcome_t exp;
      if (outcomes.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: hit=%0d idx=%0d wb=%0d blk=%h fill=%0d last=%0d",
                   got.hit, got.entry, got.wb, got.wb_block, got.fill, got.last);
        return;
      end
      exp = outcomes.pop_front();
      if (got.hit !== exp.hit || got.entry !== exp.entry || got.wb !== exp.wb ||
          got.wb_block !== exp.wb_block || got.fill !== exp.fill || got.last !== exp.last) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected hit=%0d idx=%0d wb=%0d blk=%h fill=%0d last=%0d",
                   $time, exp.hit, exp.entry, exp.wb, exp.wb_block, exp.fill, exp.last);
          $display("                 actual   hit=%0d idx=%0d wb=%0d blk=%h fill=%0d last=%0d",
                   got.hit, got.entry, got.wb, got.wb_block, got.fill, got.last);
        end
      end
    endfunction

    function void close_out();
      if (outcomes.size() != 0) begin
        errors++;
        $display("%0d expected transactions never arrived", outcomes.size());
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_action;
  logic [BLOCK_BITS-1:0] in_block_number;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_hit;
  logic [IDX_W-1:0]      out_entry_index;
  logic                  out_writeback_needed;
  logic [BLOCK_BITS-1:0] out_writeback_block;
  logic                  out_fill_needed;
  logic                  out_last;

  directory_scoreboard   sb;
  logic [BLOCK_BITS-1:0] block_pool [POOL_SIZE];
  bit                    fast_mode;
  int                    ready_hold;

  lru_writeback_block_cache_directory #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .BLOCK_BITS (BLOCK_BITS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_entry_index     (out_entry_index),
    .out_writeback_needed(out_writeback_needed),
    .out_writeback_block (out_writeback_block),
    .out_fill_needed     (out_fill_needed),
    .out_last            (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_request(action_t act, logic [BLOCK_BITS-1:0] blk);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_block_number <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(act, blk);
  endtask

  // result side: hold ready low for a drawn number of cycles before each transaction
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_outcome('{hit: out_hit, entry: out_entry_index, wb: out_writeback_needed,
                         wb_block: out_writeback_block, fill: out_fill_needed,
                         last: out_last});
      ready_hold = fast_mode ? 0 : $urandom_range(0, 14);
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    action_t               act;
    logic [BLOCK_BITS-1:0] blk;
    int                    r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_READ;
    in_block_number = '0;
    out_ready = 1'b0;
    ready_hold = 0;
    fast_mode = 0;
    sb = new();
    for (int i = 0; i < POOL_SIZE; i++) block_pool[i] = $urandom;
    block_pool[0] = '0;
    block_pool[1] = '1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, hits, fills, flushes, empty flush, invalidate
    send_request(ACT_WRITE, 32'h0000_0000);
    send_request(ACT_READ,  32'h0000_0000);
    send_request(ACT_READ,  32'hFFFF_FFFF);
    send_request(ACT_WRITE, 32'hFFFF_FFFF);
    send_request(ACT_READ,  32'h1234_5678);
    send_request(ACT_FLUSH, 32'hFFFF_FFFF);
    send_request(ACT_FLUSH, 32'h0000_0000);
    send_request(ACT_WRITE, 32'hAAAA_AAAA);
    send_request(ACT_WRITE, 32'h5555_5555);
    send_request(ACT_INVAL, 32'hFFFF_FFFF);
    send_request(ACT_READ,  32'h0000_0000);
    send_request(ACT_FLUSH, 32'h0000_0000);
    send_request(ACT_WRITE, 32'h0000_0000);
    send_request(ACT_INVAL, 32'h0000_0000);
    send_request(ACT_FLUSH, 32'h0000_0000);
    send_request(ACT_READ,  32'h0000_0001);
    send_request(ACT_WRITE, 32'h8000_0000);
    send_request(ACT_READ,  32'h7FFF_FFFF);
    send_request(ACT_WRITE, 32'hFFFF_FFFE);
    send_request(ACT_READ,  32'h0000_0001);
    send_request(ACT_WRITE, 32'h8000_0000);
    send_request(ACT_FLUSH, 32'h5A5A_A5A5);

    // random: block numbers mostly from a pool larger than the cache, forcing evictions
    for (int n = 0; n < 137; n++) begin
      if (n % 20 == 0) fast_mode = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) act = ACT_READ;
      else if (r < 88) act = ACT_WRITE;
      else if (r < 97) act = ACT_FLUSH;
      else act = ACT_INVAL;
      if ($urandom_range(0, 99) < 85) blk = block_pool[$urandom_range(0, POOL_SIZE - 1)];
      else blk = $urandom;
      send_request(act, blk);
    end
    send_request(ACT_FLUSH, $urandom);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outcomes.size() != 0) @(posedge clk);
    repeat (NUM_ENTRIES * 4) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/lrud_pkg.sv
design/lrud_cell.sv
design/lru_writeback_block_cache_directory.sv
design/lrud_checker.sv
test/testbench.sv
